FILE: rtl/ddm_pkg.sv
// Shared types and constants for the differential drive mixer.
// No dependencies; every other rtl file refers to this package by scoped name.
`timescale 1ns / 1ps

package ddm_pkg;

  // drive magnitude at 100 percent
  localparam logic [6:0] FULL_SCALE = 7'd127;
  localparam logic [6:0] SPEED_MAX  = 7'd100;

  // blend slope 2.222 in Q16
  localparam logic signed [18:0] BLEND_Q16 = 19'sd145621;

  // floor(n / 100) == (n * 5243) >> 19 for n below 43699
  localparam logic [12:0]  RECIP_100   = 13'd5243;
  localparam int unsigned  RECIP_SHIFT = 19;

  typedef enum logic [3:0] {
    REG_NONE,
    REG_FWD,     // heading 90
    REG_Q1,      // 0 < a < 90, right wheel blended
    REG_SPIN_R,  // heading 0 or 360
    REG_Q2,      // 90 < a < 180, left wheel blended
    REG_SPIN_L,  // heading 180
    REG_Q3,      // 180 < a < 270, right wheel blended
    REG_REV,     // heading 270
    REG_Q4       // 270 < a < 360, left wheel blended
  } region_t;

  typedef enum logic [1:0] {
    ACT_BRAKE = 2'd0,
    ACT_FWD   = 2'd1,
    ACT_REV   = 2'd2
  } action_t;

  typedef struct packed {
    logic [6:0] brake;
    logic [6:0] speed;
    region_t    region;
  } ctx_t;

  // load enables, one per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } pipe_en_t;

  typedef struct packed {
    action_t            action;
    logic [6:0]         level;
    logic signed [7:0]  speed;
  } wheel_t;

endpackage

FILE: rtl/ddm_front.sv
// Front end: heading fold, region decode, speed clamp and the blend product (stages 1-3).
// Depends on ddm_pkg.
`timescale 1ns / 1ps

module ddm_front (
  input  logic                clk,
  input  ddm_pkg::pipe_en_t   en,
  input  logic [6:0]          brake_level,
  input  logic [6:0]          speed_percent,
  input  logic signed [9:0]   heading_deg,
  output ddm_pkg::ctx_t       ctx,
  output logic signed [31:0]  prod
);

  logic signed [10:0] ang;
  logic [6:0]         v_sat;
  ddm_pkg::region_t   region;
  logic signed [6:0]  dsel;

  ddm_pkg::ctx_t      ctx1_r, ctx2_r, ctx3_r;
  logic signed [6:0]  ds1_r;
  logic signed [14:0] p2_r, p_nxt;
  logic signed [31:0] q3_r, q_nxt;

  always_comb begin
    ang = 11'(heading_deg);
    if (heading_deg < 10'sd0) begin
      ang = ang + 11'sd360;
    end
    v_sat = (speed_percent > ddm_pkg::SPEED_MAX) ? ddm_pkg::SPEED_MAX : speed_percent;

    // dsel already carries the blend sign
    region = ddm_pkg::REG_NONE;
    dsel   = '0;
    if (ang == 11'sd90) begin
      region = ddm_pkg::REG_FWD;
    end else if (ang > 11'sd0 && ang < 11'sd90) begin
      region = ddm_pkg::REG_Q1;
      dsel   = 7'(ang - 11'sd45);
    end else if (ang == 11'sd0 || ang == 11'sd360) begin
      region = ddm_pkg::REG_SPIN_R;
    end else if (ang > 11'sd90 && ang < 11'sd180) begin
      region = ddm_pkg::REG_Q2;
      dsel   = 7'(11'sd135 - ang);
    end else if (ang == 11'sd180) begin
      region = ddm_pkg::REG_SPIN_L;
    end else if (ang > 11'sd180 && ang < 11'sd270) begin
      region = ddm_pkg::REG_Q3;
      dsel   = 7'(11'sd225 - ang);
    end else if (ang == 11'sd270) begin
      region = ddm_pkg::REG_REV;
    end else if (ang > 11'sd270 && ang < 11'sd360) begin
      region = ddm_pkg::REG_Q4;
      dsel   = 7'(ang - 11'sd315);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ctx1_r <= '{brake: brake_level, speed: v_sat, region: region};
      ds1_r  <= dsel;
    end
  end

  assign p_nxt = $signed({1'b0, ctx1_r.speed}) * ds1_r;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      ctx2_r <= ctx1_r;
      p2_r   <= p_nxt;
    end
  end

  assign q_nxt = p2_r * ddm_pkg::BLEND_Q16;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ctx3_r <= ctx2_r;
      q3_r   <= q_nxt;
    end
  end

  assign ctx  = ctx3_r;
  assign prod = q3_r;

endmodule

FILE: rtl/ddm_blend.sv
// Blend ceiling division and wheel speed selection (stages 4-5).
// Depends on ddm_pkg.
`timescale 1ns / 1ps

module ddm_blend (
  input  logic               clk,
  input  ddm_pkg::pipe_en_t  en,
  input  ddm_pkg::ctx_t      ctx,
  input  logic signed [31:0] prod,
  output logic [6:0]         brake,
  output logic signed [7:0]  left_speed,
  output logic signed [7:0]  right_speed
);

  logic signed [31:0] sum, ysh;
  logic signed [15:0] y;
  logic [15:0]        ymag;
  logic [13:0]        n_nxt, n4_r;
  logic               neg4_r;
  ddm_pkg::ctx_t      ctx4_r;

  logic [26:0]        mul5;
  logic [6:0]         quot;
  logic signed [7:0]  bl, v, ls_nxt, rs_nxt;
  logic signed [7:0]  ls5_r, rs5_r;
  logic [6:0]         brake5_r;

  // ceil over the Q16 scale first, then ceil over 100
  always_comb begin
    sum  = prod + 32'sd65535;
    ysh  = sum >>> 16;
    y    = ysh[15:0];
    ymag = y[15] ? 16'(-y) : 16'(y);
    n_nxt = y[15] ? ymag[13:0] : ymag[13:0] + 14'd99;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      ctx4_r <= ctx;
      n4_r   <= n_nxt;
      neg4_r <= y[15];
    end
  end

  always_comb begin
    mul5 = 27'(n4_r) * 27'(ddm_pkg::RECIP_100);
    quot = mul5[ddm_pkg::RECIP_SHIFT +: 7];
    bl   = neg4_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    v    = $signed({1'b0, ctx4_r.speed});
    case (ctx4_r.region)
      ddm_pkg::REG_FWD: begin
        ls_nxt = v;  rs_nxt = v;
      end
      ddm_pkg::REG_Q1: begin
        ls_nxt = v;  rs_nxt = bl;
      end
      ddm_pkg::REG_SPIN_R: begin
        ls_nxt = v;  rs_nxt = -v;
      end
      ddm_pkg::REG_Q2: begin
        ls_nxt = bl; rs_nxt = v;
      end
      ddm_pkg::REG_SPIN_L: begin
        ls_nxt = -v; rs_nxt = v;
      end
      ddm_pkg::REG_Q3: begin
        ls_nxt = -v; rs_nxt = bl;
      end
      ddm_pkg::REG_REV: begin
        ls_nxt = -v; rs_nxt = -v;
      end
      ddm_pkg::REG_Q4: begin
        ls_nxt = bl; rs_nxt = -v;
      end
      default: begin
        ls_nxt = '0; rs_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      ls5_r    <= ls_nxt;
      rs5_r    <= rs_nxt;
      brake5_r <= ctx4_r.brake;
    end
  end

  assign brake       = brake5_r;
  assign left_speed  = ls5_r;
  assign right_speed = rs5_r;

endmodule

FILE: rtl/ddm_scale.sv
// One wheel: scale percent to full scale, truncate, form action/level/speed (stages 6-7).
// Depends on ddm_pkg.
`timescale 1ns / 1ps

module ddm_scale (
  input  logic               clk,
  input  ddm_pkg::pipe_en_t  en,
  input  logic [6:0]         brake,
  input  logic signed [7:0]  speed_in,
  output ddm_pkg::wheel_t    wheel
);

  logic [6:0]       mag;
  logic [13:0]      prod_nxt, prod6_r;
  logic             neg6_r;
  logic [6:0]       brake6_r;

  logic [26:0]      mul7;
  logic [6:0]       sc;
  ddm_pkg::wheel_t  wheel_nxt, wheel_r;

  always_comb begin
    mag      = speed_in[7] ? 7'(-speed_in) : speed_in[6:0];
    prod_nxt = 14'(mag) * 14'(ddm_pkg::FULL_SCALE);
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      prod6_r  <= prod_nxt;
      neg6_r   <= speed_in[7];
      brake6_r <= brake;
    end
  end

  always_comb begin
    mul7 = 27'(prod6_r) * 27'(ddm_pkg::RECIP_100);
    sc   = mul7[ddm_pkg::RECIP_SHIFT +: 7];
    if (brake6_r != 7'd0) begin
      wheel_nxt = '{action: ddm_pkg::ACT_BRAKE, level: brake6_r, speed: 8'sd0};
    end else if (sc == 7'd0) begin
      wheel_nxt = '{action: ddm_pkg::ACT_BRAKE, level: 7'd0, speed: 8'sd0};
    end else if (neg6_r) begin
      wheel_nxt = '{action: ddm_pkg::ACT_REV, level: sc, speed: -$signed({1'b0, sc})};
    end else begin
      wheel_nxt = '{action: ddm_pkg::ACT_FWD, level: sc, speed: $signed({1'b0, sc})};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s7) begin
      wheel_r <= wheel_nxt;
    end
  end

  assign wheel = wheel_r;

endmodule

FILE: rtl/differential_drive_mixer.sv
// Differential drive mixer top level: stream handshake, stage valids, datapath instances.
// Depends on ddm_pkg, ddm_front, ddm_blend, ddm_scale.
//
//  channel | dir | width | contents (low bit first)
//  in_     | in  |  24   | brake_level[6:0], speed_percent[13:7], heading_deg[23:14]
//  out_    | out |  40   | left action/level/speed, right action/level/speed, zero pad
//
// Seven register stages, s1 through s7.
// One word per cycle sustained while the output is not held off: every stage is a plain
// register, the blend multiply and the two reciprocal divides each own a stage.
// rst_n (synchronous) clears the stage valid bits only; payload is not reset.
// A stage loads when it is empty or the stage after it moves, so bubbles close
// up under a stalled output and no word is lost or repeated.
`timescale 1ns / 1ps

module differential_drive_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // brake_level, speed_percent, heading_deg
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // left_action, left_level, left_speed,
                                  // right_action, right_level, right_speed, pad
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0]    vld_r, vld_nxt, rdy, up_vld;
  ddm_pkg::pipe_en_t  en;

  ddm_pkg::ctx_t      ctx;
  logic signed [31:0] prod;
  logic [6:0]         brake;
  logic signed [7:0]  ls, rs;
  ddm_pkg::wheel_t    lw, rw;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    up_vld  = {vld_r[NSTG-2:0], in_tvalid};
    vld_nxt = (rdy & up_vld) | (~rdy & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3],
                s5: rdy[4], s6: rdy[5], s7: rdy[6]};

  ddm_front u_front (
    .clk           (clk),
    .en            (en),
    .brake_level   (in_tdata[6:0]),
    .speed_percent (in_tdata[13:7]),
    .heading_deg   ($signed(in_tdata[23:14])),
    .ctx           (ctx),
    .prod          (prod)
  );

  ddm_blend u_blend (
    .clk         (clk),
    .en          (en),
    .ctx         (ctx),
    .prod        (prod),
    .brake       (brake),
    .left_speed  (ls),
    .right_speed (rs)
  );

  ddm_scale u_scale_l (
    .clk      (clk),
    .en       (en),
    .brake    (brake),
    .speed_in (ls),
    .wheel    (lw)
  );

  ddm_scale u_scale_r (
    .clk      (clk),
    .en       (en),
    .brake    (brake),
    .speed_in (rs),
    .wheel    (rw)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {6'd0,
                       rw.speed, rw.level, rw.action,
                       lw.speed, lw.level, lw.action};

endmodule

FILE: rtl/ddm_checker.sv
// Port-level checks for differential_drive_mixer, attached by bind.
// Depends on ddm_pkg and the top level's port list.
`timescale 1ns / 1ps

module ddm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a held output word must not move
  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // brake action exactly when the reported speed is zero, both wheels
  ast_brake_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((out_tdata[1:0] == ddm_pkg::ACT_BRAKE) == (out_tdata[16:9] == 8'd0)) &&
      ((out_tdata[18:17] == ddm_pkg::ACT_BRAKE) == (out_tdata[33:26] == 8'd0)))
    else $error("brake action and speed disagree");

  // left wheel forward drive: level equals the positive speed
  ast_fwd_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ddm_pkg::ACT_FWD |->
      out_tdata[8:2] == out_tdata[15:9] && !out_tdata[16])
    else $error("left forward level does not match speed");

  // reset empties the pipe
  ast_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind differential_drive_mixer ddm_checker u_ddm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for differential_drive_mixer: directed corner commands, then
// random commands under random stalls on both stream sides, scoreboarded in order.
// Depends on ddm_pkg and rtl/differential_drive_mixer.sv.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    ddm_pkg::action_t  action;
    logic [6:0]        level;
    logic signed [7:0] speed;
  } wheel_cmd_t;

  typedef struct {
    wheel_cmd_t left;
    wheel_cmd_t right;
  } wheel_pair_t;

  class mixer_scoreboard;
    wheel_pair_t wheel_q[$];
    int n_taken;
    int n_checked;
    int n_errors;
    int n_brake;
    int n_blend;
    int n_odd_heading;

    // ceil(v * d * sgn * 2.222 / 100) with the slope in Q16
    function longint blend_pct(longint v, longint d, longint sgn);
      longint num;
      longint den;
      num = v * d * sgn * longint'(ddm_pkg::BLEND_Q16);
      den = 64'sd6553600;
      if (num >= 0)
        return (num + den - 1) / den;
      return -((-num) / den);
    endfunction

    function wheel_cmd_t to_wheel(longint s);
      wheel_cmd_t w;
      longint mag;
      longint scaled;
      mag = (s < 0) ? -s : s;
      scaled = (mag * longint'(ddm_pkg::FULL_SCALE)) / 100;
      if (s < 0)
        scaled = -scaled;
      if (scaled > 0) begin
        w.action = ddm_pkg::ACT_FWD;
        w.level  = scaled[6:0];
      end else if (scaled < 0) begin
        w.action = ddm_pkg::ACT_REV;
        w.level  = 7'(-scaled);
      end else begin
        w.action = ddm_pkg::ACT_BRAKE;
        w.level  = 7'd0;
      end
      w.speed = scaled[7:0];
      return w;
    endfunction

    function void note_command(logic [23:0] word);
      logic [6:0]        brake;
      longint            v;
      logic signed [9:0] hdg;
      longint            a;
      longint            ls;
      longint            rs;
      wheel_pair_t       res;
      brake = word[6:0];
      v     = longint'(word[13:7]);
      hdg   = word[23:14];
      a     = longint'(hdg);
      ls    = 0;
      rs    = 0;
      n_taken++;
      if (brake != 7'd0) begin
        n_brake++;
        res.left  = '{ddm_pkg::ACT_BRAKE, brake, 8'sd0};
        res.right = '{ddm_pkg::ACT_BRAKE, brake, 8'sd0};
        wheel_q.push_back(res);
        return;
      end
      if (v > longint'(ddm_pkg::SPEED_MAX))
        v = longint'(ddm_pkg::SPEED_MAX);
      if (a < 0)
        a += 360;
      if (a == 90) begin
        ls = v; rs = v;
      end else if (a > 0 && a < 90) begin
        ls = v; rs = blend_pct(v, a - 45, 1);
      end else if (a == 0 || a == 360) begin
        ls = v; rs = -v;
      end else if (a > 90 && a < 180) begin
        ls = blend_pct(v, a - 135, -1); rs = v;
      end else if (a == 180) begin
        ls = -v; rs = v;
      end else if (a > 180 && a < 270) begin
        ls = -v; rs = blend_pct(v, a - 225, -1);
      end else if (a == 270) begin
        ls = -v; rs = -v;
      end else if (a > 270 && a < 360) begin
        ls = blend_pct(v, a - 315, 1); rs = -v;
      end else begin
        n_odd_heading++;
      end
      if (a % 90 != 0 && a > 0 && a < 360)
        n_blend++;
      res.left  = to_wheel(ls);
      res.right = to_wheel(rs);
      wheel_q.push_back(res);
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        n_errors++;
        $error("%s mismatch on word %0d: expected %0d, got %0d",
               name, n_checked, exp_val, got_val);
      end
    endfunction

    function void check_word(logic [39:0] word);
      wheel_pair_t e;
      if (wheel_q.size() == 0) begin
        n_errors++;
        $error("result word with no command outstanding: %h", word);
        return;
      end
      e = wheel_q.pop_front();
      compare_field("left_action",  int'(e.left.action),  int'(word[1:0]));
      compare_field("left_level",   int'(e.left.level),   int'(word[8:2]));
      compare_field("left_speed",   int'(e.left.speed),   int'($signed(word[16:9])));
      compare_field("right_action", int'(e.right.action), int'(word[18:17]));
      compare_field("right_level",  int'(e.right.level),  int'(word[25:19]));
      compare_field("right_speed",  int'(e.right.speed),  int'($signed(word[33:26])));
      n_checked++;
    endfunction

    function int pending();
      return wheel_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  mixer_scoreboard board = new();
  int unsigned     cycle_cnt = 0;
  int              hold_cnt = 0;

  always #5 clk = ~clk;

  differential_drive_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // mostly no gap or a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // word monitors
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && in_tvalid && in_tready)
      board.note_command(in_tdata);
    if (rst_n && out_tvalid && out_tready)
      board.check_word(out_tdata);
  end

  // output back-pressure; new stalls start only while bit 8 of cycle_cnt is clear
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else begin
      out_tready <= 1'b1;
      if (!cycle_cnt[8] && $urandom_range(0, 3) == 0)
        hold_cnt <= gap_len();
    end
  end

  task automatic send_cmd(input logic [6:0] brake, input logic [6:0] spd, input int hdg,
                          input bit calm);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {10'(hdg), spd, brake};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int  r;
    int  hdg;
    logic [6:0] brake;
    logic [6:0] spd;
    bit  calm;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // braking, speed limits, every axis and both sides of it, folding, headings out of range
    send_cmd(7'd127, 7'd50,  90,   1'b0);
    send_cmd(7'd1,   7'd100, -359, 1'b0);
    send_cmd(7'd0,   7'd0,   90,   1'b0);
    send_cmd(7'd0,   7'd127, 90,   1'b0);
    send_cmd(7'd0,   7'd101, 45,   1'b0);
    send_cmd(7'd0,   7'd100, 0,    1'b0);
    send_cmd(7'd0,   7'd100, 360,  1'b0);
    send_cmd(7'd0,   7'd100, 180,  1'b0);
    send_cmd(7'd0,   7'd100, 270,  1'b0);
    send_cmd(7'd0,   7'd100, 1,    1'b0);
    send_cmd(7'd0,   7'd100, 89,   1'b0);
    send_cmd(7'd0,   7'd100, 91,   1'b0);
    send_cmd(7'd0,   7'd100, 179,  1'b0);
    send_cmd(7'd0,   7'd100, 181,  1'b0);
    send_cmd(7'd0,   7'd100, 269,  1'b0);
    send_cmd(7'd0,   7'd100, 271,  1'b0);
    send_cmd(7'd0,   7'd100, 359,  1'b0);
    send_cmd(7'd0,   7'd100, -1,   1'b0);
    send_cmd(7'd0,   7'd100, -360, 1'b0);
    send_cmd(7'd0,   7'd100, -512, 1'b0);
    send_cmd(7'd0,   7'd100, 511,  1'b0);
    send_cmd(7'd0,   7'd100, 361,  1'b0);
    send_cmd(7'd0,   7'd100, -361, 1'b0);
    send_cmd(7'd0,   7'd1,   46,   1'b0);
    send_cmd(7'd0,   7'd77,  134,  1'b0);

    for (int i = 0; i < 900; i++) begin
      calm  = (i % 128) < 32;
      brake = ($urandom_range(0, 9) < 7) ? 7'd0 : 7'($urandom_range(1, 127));
      spd   = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 100))
                                           : 7'($urandom_range(101, 127));
      r = $urandom_range(0, 99);
      if (r < 80)
        hdg = int'($urandom_range(0, 718)) - 359;
      else if (r < 90)  // near an axis or a blend centre
        hdg = 45 * int'($urandom_range(0, 8)) + int'($urandom_range(0, 4)) - 2
              - (($urandom_range(0, 1) == 1) ? 360 : 0);
      else
        hdg = int'($urandom_range(0, 1023)) - 512;
      send_cmd(brake, spd, hdg, calm);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.pending() != 0) begin
      board.n_errors++;
      $error("%0d expected results never arrived", board.pending());
    end

    $display("Commands taken %0d, results checked %0d (braking %0d, blended headings %0d,",
             board.n_taken, board.n_checked, board.n_brake, board.n_blend);
    $display("headings outside every case %0d), under random stalls on both sides",
             board.n_odd_heading);
    if (board.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out waiting on the mixer");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
